// File: sv/aes_cfb_pkg.sv
// ----------------------------------------------------------------------------
// aes_cfb_pkg
// S-box table, register indexes and round helpers for the AES-128 CFB unit.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_cfb_pkg;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_IV_HIGH  = 2'd2;
  localparam logic [1:0] REG_IV_LOW   = 2'd3;
  localparam int unsigned NUM_ROUNDS  = 10;
  localparam logic [7:0] RCON_FIRST   = 8'h01;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] tab [256];
    tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tab[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte 0 of the block sits in bits 127:120
  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = sbox(s[127-8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++) t[4*c+k] = b[4*((c+k)%4)+k];
    for (int c = 0; c < 4; c++) begin
      if (last) begin
        for (int k = 0; k < 4; k++) r[127-8*(4*c+k) -: 8] = t[4*c+k];
      end else begin
        r[127-8*(4*c)   -: 8] = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2]
                                ^ t[4*c+3];
        r[127-8*(4*c+1) -: 8] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2]
                                ^ t[4*c+3];
        r[127-8*(4*c+2) -: 8] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3])
                                ^ t[4*c+3];
        r[127-8*(4*c+3) -: 8] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2]
                                ^ xtime(t[4*c+3]);
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] tmp;
    logic [127:0] n;
    tmp = {sbox(k[23:16]), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])} ^ {rc, 24'h0};
    n[127:96] = k[127:96] ^ tmp;
    n[95:64]  = k[95:64] ^ n[127:96];
    n[63:32]  = k[63:32] ^ n[95:64];
    n[31:0]   = k[31:0] ^ n[63:32];
    return n;
  endfunction

endpackage
`default_nettype wire

// File: sv/aes128_cfb_cipher_unit.sv
// ----------------------------------------------------------------------------
// aes128_cfb_cipher_unit
// AES-128 CFB128 block unit with one shared round and on-the-fly key schedule.
// ----------------------------------------------------------------------------
// Each word runs 10 rounds in ST_ROUND; the output XOR is applied in the last round.
// A new word is accepted only in ST_IDLE once the previous result has been taken.
// One round of the cipher and one key expansion step run per cycle.
// Reset clears key, IV, feedback and control registers, not the datapath; no clearing pass.
`default_nettype none
module aes128_cfb_cipher_unit
  import aes_cfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic        in_first_block,
  input  wire logic [63:0] in_data_high,
  input  wire logic [63:0] in_data_low,
  input  wire logic [4:0]  in_valid_bytes,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_result_high,
  output logic [63:0]      out_result_low,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_DONE  = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [127:0]  key_r, iv_r, fb_r, st_r, rk_r, data_r, res_r;
  logic [3:0]    rnd_r;
  logic [7:0]    rc_r;
  logic          mode_r, out_valid_r;
  logic [4:0]    nb_r;
  logic [127:0]  rk_n, ks, fb_src;
  logic [127:0]  res_c, fb_c;

  assign cfg_ready       = 1'b1;
  assign in_ready        = (state_r == ST_IDLE) && !out_valid_r;
  assign out_valid       = out_valid_r;
  assign out_result_high = res_r[127:64];
  assign out_result_low  = res_r[63:0];

  assign rk_n   = next_key(rk_r, rc_r);
  assign ks     = round_fn(st_r, rnd_r == 4'(NUM_ROUNDS)) ^ rk_n;
  assign fb_src = in_first_block ? iv_r : fb_r;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < nb_r) begin
        res_c[127-8*i -: 8] = data_r[127-8*i -: 8] ^ ks[127-8*i -: 8];
        fb_c[127-8*i -: 8]  = mode_r ? data_r[127-8*i -: 8] : res_c[127-8*i -: 8];
      end else begin
        res_c[127-8*i -: 8] = 8'h00;
        fb_c[127-8*i -: 8]  = fb_r[127-8*i -: 8];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid && in_ready) state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == 4'(NUM_ROUNDS)) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      key_r       <= '0;
      iv_r        <= '0;
      fb_r        <= '0;
      rnd_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_KEY_HIGH: key_r[127:64] <= cfg_data;
          REG_KEY_LOW:  key_r[63:0]   <= cfg_data;
          REG_IV_HIGH:  iv_r[127:64]  <= cfg_data;
          REG_IV_LOW:   iv_r[63:0]    <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            st_r   <= fb_src ^ key_r;
            fb_r   <= fb_src;
            rk_r   <= key_r;
            rc_r   <= RCON_FIRST;
            rnd_r  <= 4'd1;
            mode_r <= in_mode;
            nb_r   <= (in_valid_bytes > 5'd16) ? 5'd16 : in_valid_bytes;
            data_r <= {in_data_high, in_data_low};
          end
        end
        ST_ROUND: begin
          if (rnd_r == 4'(NUM_ROUNDS)) begin
            res_r       <= res_c;
            fb_r        <= fb_c;
            out_valid_r <= 1'b1;
          end else begin
            st_r  <= ks;
            rk_r  <= rk_n;
            rc_r  <= xtime(rc_r);
            rnd_r <= rnd_r + 4'd1;
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("accept while busy");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (rnd_r >= 4'd1 && rnd_r <= 4'(NUM_ROUNDS)))
    else $error("round count out of range");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> out_valid_r) else $error("done without output");
  a_accept_round: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_ROUND && rnd_r == 4'd1))
    else $error("accept did not start rounds");
`endif

endmodule
`default_nettype wire
